[hw/rtl/bgi_pkg.sv]
// Shared constants, codes and types of the bilinear grid interpolator.
// No dependencies; the other files that use it refer to it by scoped names.
`default_nettype none

package bgi_pkg;

  // Default table sizes and fixed-point format
  localparam int unsigned MAX_X_POINTS  = 64;
  localparam int unsigned MAX_Y_POINTS  = 64;
  localparam int unsigned FRACTION_BITS = 16;

  // Blend accumulator: holds every partial term of the blend without loss
  localparam int unsigned ACC_W = 100;

  // Input word actions
  localparam logic [1:0] ACT_LOAD_X    = 2'd0;
  localparam logic [1:0] ACT_LOAD_Y    = 2'd1;
  localparam logic [1:0] ACT_LOAD_GRID = 2'd2;
  localparam logic [1:0] ACT_QUERY     = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NEGATIVE   = 2'd1;
  localparam logic [1:0] ST_SATURATED  = 2'd2;
  localparam logic [1:0] ST_ZERO_WIDTH = 2'd3;

  // Bounding points of the cell found on one axis
  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } bgi_cell_t;

endpackage

`default_nettype wire

[hw/rtl/bgi_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bgi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/bgi_axis.sv]
// Axis table with its cell search: holds the points of one axis in a RAM and
// finds the cell around a coordinate by a linear scan. Uses bgi_pkg, bgi_ram.
`default_nettype none

module bgi_axis #(
  parameter int unsigned DEPTH = bgi_pkg::MAX_X_POINTS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  wire logic [31:0]                wr_data_i,
  input  wire logic [$clog2(DEPTH+1)-1:0] count_i,
  input  wire logic                       start_i,
  input  wire logic signed [31:0]         coord_i,
  output logic                            done_o,
  output bgi_pkg::bgi_cell_t              cell_o,
  output logic [$clog2(DEPTH)-1:0]        idx_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CK   = 2'd2;

  localparam logic [2:0] P_FIRST = 3'd0;
  localparam logic [2:0] P_LAST  = 3'd1;
  localparam logic [2:0] P_SCAN  = 3'd2;
  localparam logic [2:0] P_LO    = 3'd3;
  localparam logic [2:0] P_HI    = 3'd4;

  logic [1:0]         st_q, st_d;
  logic [2:0]         ph_q, ph_d;
  logic [AW-1:0]      ka_q, ka_d;
  logic [AW-1:0]      k_q, k_d;
  logic signed [31:0] lo_q, lo_d, hi_q, hi_d;
  logic               done_q, done_d;
  logic [31:0]        rdata;
  logic signed [31:0] pt;
  logic [AW-1:0]      last, last_m1;

  bgi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_data_i),
    .raddr_i (ka_q),
    .rdata_o (rdata)
  );

  assign pt      = $signed(rdata);
  assign last    = AW'(count_i - CW'(1));
  assign last_m1 = AW'(count_i - CW'(2));

  always_comb begin
    st_d   = st_q;
    ph_d   = ph_q;
    ka_d   = ka_q;
    k_d    = k_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    done_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (start_i) begin
          ka_d = '0;
          ph_d = P_FIRST;
          st_d = S_RD;
        end
      end
      S_RD: begin
        st_d = S_CK;
      end
      S_CK: begin
        st_d = S_RD;
        case (ph_q)
          P_FIRST: begin
            if (coord_i < pt) begin
              k_d  = AW'(1);
              ka_d = '0;
              ph_d = P_LO;
            end else begin
              ka_d = last;
              ph_d = P_LAST;
            end
          end
          P_LAST: begin
            if (coord_i >= pt || count_i == CW'(2)) begin
              k_d  = last;
              ka_d = last_m1;
              ph_d = P_LO;
            end else begin
              ka_d = AW'(1);
              ph_d = P_SCAN;
            end
          end
          P_SCAN: begin
            if (pt > coord_i) begin
              k_d  = ka_q;
              ka_d = ka_q - AW'(1);
              ph_d = P_LO;
            end else if (ka_q == last_m1) begin
              k_d  = last;
              ka_d = last_m1;
              ph_d = P_LO;
            end else begin
              ka_d = ka_q + AW'(1);
            end
          end
          P_LO: begin
            lo_d = pt;
            ka_d = k_q;
            ph_d = P_HI;
          end
          P_HI: begin
            hi_d   = pt;
            done_d = 1'b1;
            st_d   = S_IDLE;
          end
          default: begin
            st_d = S_IDLE;
          end
        endcase
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ph_q   <= P_FIRST;
      ka_q   <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      ph_q   <= ph_d;
      ka_q   <= ka_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q  <= k_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign done_o    = done_q;
  assign cell_o.lo = lo_q;
  assign cell_o.hi = hi_q;
  assign idx_o     = k_q;

endmodule

`default_nettype wire

[hw/rtl/bgi_div.sv]
// Restoring divider for the cell fractions: (num * 2^FRAC) / den, truncated
// toward zero and saturated to 32 bits signed. Uses bgi_pkg for its default.
`default_nettype none

module bgi_div #(
  parameter int unsigned FRAC = bgi_pkg::FRACTION_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [32:0] num_i,
  input  wire logic signed [32:0] den_i,
  output logic                    done_o,
  output logic signed [31:0]      quot_o
);

  localparam int unsigned NW = 32 + FRAC;
  localparam int unsigned NCW = $clog2(NW + 1);

  logic           busy_q;
  logic [NCW-1:0] cnt_q;
  logic [NW-1:0]  dv_q;
  logic [NW-1:0]  qt_q;
  logic [31:0]    rem_q;
  logic [31:0]    dvs_q;
  logic           neg_q;
  logic           done_q;
  logic signed [31:0] quot_q;

  logic [32:0] num_mag, den_mag;
  logic [32:0] trial;
  logic        fits;
  logic        big_pos, big_neg;
  logic [31:0] sat_val;

  assign num_mag = num_i[32] ? 33'(-num_i) : 33'(num_i);
  assign den_mag = den_i[32] ? 33'(-den_i) : 33'(den_i);
  assign trial   = {rem_q, dv_q[NW-1]};
  assign fits    = trial >= {1'b0, dvs_q};

  assign big_pos = |qt_q[NW-1:31];
  assign big_neg = (|qt_q[NW-1:32]) || (qt_q[31] && (|qt_q[30:0]));

  always_comb begin
    if (neg_q) begin
      sat_val = big_neg ? 32'h8000_0000 : 32'(-qt_q[31:0]);
    end else begin
      sat_val = big_pos ? 32'h7FFF_FFFF : qt_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= NCW'(NW);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - NCW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dv_q  <= {num_mag[31:0], {FRAC{1'b0}}};
      dvs_q <= den_mag[31:0];
      rem_q <= '0;
      qt_q  <= '0;
      neg_q <= num_i[32] ^ den_i[32];
    end else if (busy_q && cnt_q != '0) begin
      // shift one dividend bit in, subtract where the divisor fits
      rem_q <= fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
      qt_q  <= {qt_q[NW-2:0], fits};
      dv_q  <= {dv_q[NW-2:0], 1'b0};
    end
    if (busy_q && cnt_q == '0) begin
      quot_q <= $signed(sat_val);
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

[hw/rtl/bilinear_grid_interpolator.sv]
// Top level of the bilinear interpolator on a rectilinear Q16.16 grid.
// Uses bgi_pkg, bgi_axis (axis tables and search), bgi_div and bgi_ram.
`default_nettype none

// The block keeps an x axis table, a y axis table and a row-major grid
// (entry i * y_points_used + j) in synchronous RAMs, none cleared by reset:
// load every point and grid value a query can touch before querying. A load
// word (action 0, 1 or 2) writes one entry and gives no result; a load_index
// beyond its table is dropped. A query word (action 3) gives one result
// word. Each axis is searched for its upper-bound cell by a linear scan of
// its RAM; the two axes are scanned at once. Coordinates below the first
// point use the first interval and those at or above the last point use the
// last one, so the block extrapolates. Then a shared restoring divider forms
// the x and y fractions, four grid reads follow and the blend with its
// rounding runs on one 33 x 35 bit multiplier. One word is worked on at a
// time; the next is taken as soon as the result is parked in the output
// register. Status reports a zero-width cell (value 0), a negative value, or
// positive saturation to the 32-bit range. Write x_points_used (address 0)
// and y_points_used (address 4) only while idle; values below 2 store 2 and
// values above the table depth store the depth.

module bilinear_grid_interpolator #(
  parameter int unsigned MAX_X_POINTS  = bgi_pkg::MAX_X_POINTS,
  parameter int unsigned MAX_Y_POINTS  = bgi_pkg::MAX_Y_POINTS,
  parameter int unsigned FRACTION_BITS = bgi_pkg::FRACTION_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input words
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [11:0] load_index_i,
  input  wire logic signed [31:0] load_value_i,
  input  wire logic signed [31:0] query_x_i,
  input  wire logic signed [31:0] query_y_i,
  // result words
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [31:0] interpolated_o,
  output logic [1:0]       status_o,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned GRID_DEPTH = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int unsigned XAW = $clog2(MAX_X_POINTS);
  localparam int unsigned XCW = $clog2(MAX_X_POINTS + 1);
  localparam int unsigned YAW = $clog2(MAX_Y_POINTS);
  localparam int unsigned YCW = $clog2(MAX_Y_POINTS + 1);
  localparam int unsigned GAW = $clog2(GRID_DEPTH);
  localparam int unsigned AW  = bgi_pkg::ACC_W;

  localparam logic [3:0] T_IDLE = 4'd0;
  localparam logic [3:0] T_SRCH = 4'd1;
  localparam logic [3:0] T_CHK  = 4'd2;
  localparam logic [3:0] T_DIVX = 4'd3;
  localparam logic [3:0] T_DIVY = 4'd4;
  localparam logic [3:0] T_GRID = 4'd5;
  localparam logic [3:0] T_MUL  = 4'd6;
  localparam logic [3:0] T_RND  = 4'd7;
  localparam logic [3:0] T_FIN  = 4'd8;

  // ---------------------------------------------------------------- registers
  logic [XCW-1:0] xn_q;
  logic [YCW-1:0] yn_q;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xn_q <= XCW'(2);
      yn_q <= YCW'(2);
    end else if (cfg_wr) begin
      // clamp the point count to [2, table depth]
      if (!paddr[2]) begin
        if (pwdata < 32'd2)                 xn_q <= XCW'(2);
        else if (pwdata > 32'(MAX_X_POINTS)) xn_q <= XCW'(MAX_X_POINTS);
        else                                xn_q <= XCW'(pwdata);
      end else begin
        if (pwdata < 32'd2)                 yn_q <= YCW'(2);
        else if (pwdata > 32'(MAX_Y_POINTS)) yn_q <= YCW'(MAX_Y_POINTS);
        else                                yn_q <= YCW'(pwdata);
      end
    end
  end

  always_comb begin
    if (paddr[1:0] != 2'd0) begin
      prdata = '0;
    end else if (paddr[2]) begin
      prdata = 32'(yn_q);
    end else begin
      prdata = 32'(xn_q);
    end
  end

  // ---------------------------------------------------------------- input side
  logic [3:0] state_q, state_d;
  logic       in_acc, query_acc;
  logic       wr_x, wr_y, wr_g;

  assign in_stall_o = (state_q != T_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign query_acc  = in_acc && (action_i == bgi_pkg::ACT_QUERY);
  assign wr_x = in_acc && (action_i == bgi_pkg::ACT_LOAD_X)
                && (32'(load_index_i) < MAX_X_POINTS);
  assign wr_y = in_acc && (action_i == bgi_pkg::ACT_LOAD_Y)
                && (32'(load_index_i) < MAX_Y_POINTS);
  assign wr_g = in_acc && (action_i == bgi_pkg::ACT_LOAD_GRID)
                && (32'(load_index_i) < GRID_DEPTH);

  logic signed [31:0] qx_q, qy_q;

  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      qx_q <= query_x_i;
      qy_q <= query_y_i;
    end
  end

  // ---------------------------------------------------------------- axis search
  // Loads are only taken while idle, so no search read ever meets a write.
  logic               xdone, ydone;
  bgi_pkg::bgi_cell_t xcell, ycell;
  logic [XAW-1:0]     xi;
  logic [YAW-1:0]     yj;
  logic               xd_q, yd_q;

  bgi_axis #(.DEPTH(MAX_X_POINTS)) u_xaxis (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_x),
    .wr_addr_i (XAW'(load_index_i)),
    .wr_data_i (load_value_i),
    .count_i   (xn_q),
    .start_i   (query_acc),
    .coord_i   (qx_q),
    .done_o    (xdone),
    .cell_o    (xcell),
    .idx_o     (xi)
  );

  bgi_axis #(.DEPTH(MAX_Y_POINTS)) u_yaxis (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_y),
    .wr_addr_i (YAW'(load_index_i)),
    .wr_data_i (load_value_i),
    .count_i   (yn_q),
    .start_i   (query_acc),
    .coord_i   (qy_q),
    .done_o    (ydone),
    .cell_o    (ycell),
    .idx_o     (yj)
  );

  logic signed [32:0] dx, dy;

  assign dx = 33'(xcell.hi) - 33'(xcell.lo);
  assign dy = 33'(ycell.hi) - 33'(ycell.lo);

  // ---------------------------------------------------------------- fractions
  logic               div_start_q, div_start_d;
  logic               div_done;
  logic signed [31:0] div_quot;
  logic signed [32:0] div_num, div_den;
  logic signed [31:0] t_q, u_q;

  assign div_num = (state_q == T_DIVY) ? 33'(qy_q) - 33'(ycell.lo)
                                       : 33'(qx_q) - 33'(xcell.lo);
  assign div_den = (state_q == T_DIVY) ? dy : dx;

  bgi_div #(.FRAC(FRACTION_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ---------------------------------------------------------------- grid reads
  logic [2:0]     gs_q;
  logic [GAW-1:0] row_hi, row_lo, col_hi, col_lo, graddr;
  logic [31:0]    grdata;
  logic signed [31:0] y1_q, y2_q, y3_q, y4_q;

  assign row_hi = GAW'(yn_q) * GAW'(xi);
  assign row_lo = row_hi - GAW'(yn_q);
  assign col_hi = GAW'(yj);
  assign col_lo = col_hi - GAW'(1);

  // corner order: (i-1, j-1), (i, j-1), (i, j), (i-1, j)
  always_comb begin
    case (gs_q[1:0])
      2'd0:    graddr = row_lo + col_lo;
      2'd1:    graddr = row_hi + col_lo;
      2'd2:    graddr = row_hi + col_hi;
      default: graddr = row_lo + col_hi;
    endcase
  end

  bgi_ram #(.WIDTH(32), .DEPTH(GRID_DEPTH)) u_grid (
    .clk_i   (clk_i),
    .we_i    (wr_g),
    .waddr_i (GAW'(load_index_i)),
    .wdata_i (load_value_i),
    .raddr_i (graddr),
    .rdata_o (grdata)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == T_GRID) begin
      case (gs_q)
        3'd1:    y1_q <= $signed(grdata);
        3'd2:    y2_q <= $signed(grdata);
        3'd3:    y3_q <= $signed(grdata);
        3'd4:    y4_q <= $signed(grdata);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- blend
  // acc = y1*2^2F + t*(y2-y1)*2^F + u*(y4-y1)*2^F + t*u*(y1-y2+y3-y4);
  // t*u is split into 32-bit halves before its product with the corner sum.
  logic [2:0]         ms_q;
  logic signed [32:0] mul_a;
  logic signed [34:0] mul_b;
  logic signed [67:0] prod_q;
  logic signed [63:0] p_q;
  logic signed [AW-1:0] acc_q;
  logic signed [34:0] dsum;
  logic signed [AW-1:0] prod_ext;

  assign dsum = 35'(y1_q) - 35'(y2_q) + 35'(y3_q) - 35'(y4_q);
  assign prod_ext = AW'(prod_q);

  always_comb begin
    case (ms_q)
      3'd0: begin
        mul_a = 33'(t_q);
        mul_b = 35'(u_q);
      end
      3'd1: begin
        mul_a = 33'(t_q);
        mul_b = 35'(y2_q) - 35'(y1_q);
      end
      3'd2: begin
        mul_a = 33'(u_q);
        mul_b = 35'(y4_q) - 35'(y1_q);
      end
      3'd3: begin
        mul_a = $signed({1'b0, p_q[31:0]});
        mul_b = dsum;
      end
      default: begin
        mul_a = 33'($signed(p_q[63:32]));
        mul_b = dsum;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == T_MUL) begin
      prod_q <= mul_a * mul_b;
      case (ms_q)
        3'd1:    p_q   <= prod_q[63:0];
        3'd2:    acc_q <= acc_q + (prod_ext <<< FRACTION_BITS);
        3'd3:    acc_q <= acc_q + (prod_ext <<< FRACTION_BITS);
        3'd4:    acc_q <= acc_q + prod_ext;
        3'd5:    acc_q <= acc_q + (prod_ext <<< 32);
        default: ;
      endcase
    end else if (state_q == T_GRID && gs_q == 3'd4) begin
      acc_q <= AW'(y1_q) <<< (2 * FRACTION_BITS);
    end else if (state_q == T_RND) begin
      // round half up at the output point
      acc_q <= acc_q + (AW'(1) <<< (2 * FRACTION_BITS - 1));
    end
  end

  // ---------------------------------------------------------------- result
  logic signed [AW-1:0] shifted;
  logic                 in_range;
  logic                 zw_q;
  logic                 out_valid_q;
  logic                 out_load;
  logic signed [31:0]   res_val;
  logic [1:0]           res_st;

  assign shifted  = acc_q >>> (2 * FRACTION_BITS);
  assign in_range = (&shifted[AW-1:31]) || !(|shifted[AW-1:31]);

  always_comb begin
    if (zw_q) begin
      res_val = '0;
      res_st  = bgi_pkg::ST_ZERO_WIDTH;
    end else if (in_range) begin
      res_val = shifted[31:0];
      res_st  = shifted[31] ? bgi_pkg::ST_NEGATIVE : bgi_pkg::ST_OK;
    end else if (shifted[AW-1]) begin
      res_val = 32'sh8000_0000;
      res_st  = bgi_pkg::ST_NEGATIVE;
    end else begin
      res_val = 32'sh7FFF_FFFF;
      res_st  = bgi_pkg::ST_SATURATED;
    end
  end

  assign out_load = (state_q == T_FIN) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      interpolated_o <= res_val;
      status_o       <= res_st;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d     = state_q;
    div_start_d = 1'b0;
    case (state_q)
      T_IDLE: begin
        if (query_acc) state_d = T_SRCH;
      end
      T_SRCH: begin
        if ((xd_q || xdone) && (yd_q || ydone)) state_d = T_CHK;
      end
      T_CHK: begin
        if (dx == '0 || dy == '0) begin
          state_d = T_FIN;
        end else begin
          div_start_d = 1'b1;
          state_d     = T_DIVX;
        end
      end
      T_DIVX: begin
        if (div_done) begin
          div_start_d = 1'b1;
          state_d     = T_DIVY;
        end
      end
      T_DIVY: begin
        if (div_done) state_d = T_GRID;
      end
      T_GRID: begin
        if (gs_q == 3'd4) state_d = T_MUL;
      end
      T_MUL: begin
        if (ms_q == 3'd5) state_d = T_RND;
      end
      T_RND: begin
        state_d = T_FIN;
      end
      T_FIN: begin
        if (out_load) state_d = T_IDLE;
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      div_start_q <= 1'b0;
      xd_q        <= 1'b0;
      yd_q        <= 1'b0;
      gs_q        <= '0;
      ms_q        <= '0;
      zw_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_start_q <= div_start_d;
      // hold each search's completion until both axes are done
      if (state_q == T_SRCH) begin
        xd_q <= xd_q || xdone;
        yd_q <= yd_q || ydone;
      end else begin
        xd_q <= 1'b0;
        yd_q <= 1'b0;
      end
      gs_q <= (state_q == T_GRID) ? gs_q + 3'd1 : 3'd0;
      ms_q <= (state_q == T_MUL)  ? ms_q + 3'd1 : 3'd0;
      if (state_q == T_CHK) begin
        zw_q <= (dx == '0 || dy == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == T_DIVX && div_done) t_q <= div_quot;
    if (state_q == T_DIVY && div_done) u_q <= div_quot;
  end

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == T_DIVX || state_q == T_DIVY))
    else $error("divider finished outside a division step");

  a_search_done_in_srch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xdone || ydone) |-> (state_q == T_SRCH))
    else $error("axis search finished outside the search step");

  a_zero_width_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_o == bgi_pkg::ST_ZERO_WIDTH) |-> (interpolated_o == '0))
    else $error("zero-width result carries a non-zero value");

  a_ok_non_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_o == bgi_pkg::ST_OK || status_o == bgi_pkg::ST_SATURATED))
      |-> !interpolated_o[31])
    else $error("non-negative status with a negative value");

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_x || wr_y || wr_g) |=> (state_q == T_IDLE))
    else $error("table write started a query");
`endif

endmodule

`default_nettype wire
